>>> rtl/bf_pkg.sv
// Package for the Blowfish block engine: request and result payload types,
// function codes and the sequencer's microcode. Depends on nothing.
`default_nettype none

package bf_pkg;

   localparam int unsigned SUBKEY_DEPTH = 18;
   localparam int unsigned SK_IDX_W     = 5;
   localparam int unsigned SBOX_COUNT   = 4;
   localparam int unsigned SBOX_DEPTH   = 256;
   localparam int unsigned STEP_W       = 2;

   typedef enum logic [1:0] {
      FUNC_SUBKEY  = 2'd0,
      FUNC_SBOX    = 2'd1,
      FUNC_ENCRYPT = 2'd2
   } func_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  table_index;
      logic [31:0] table_word;
      logic [31:0] left_half;
      logic [31:0] right_half;
   } req_type;

   typedef struct packed {
      logic [31:0] cipher_left;
      logic [31:0] cipher_right;
   } rsp_type;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE  = 2'd0;
   localparam step_type STEP_READ  = 2'd1;
   localparam step_type STEP_ROUND = 2'd2;

   typedef enum logic [1:0] {
      COND_ALWAYS = 2'd0,
      COND_START  = 2'd1,
      COND_MORE   = 2'd2
   } cond_type;

   typedef struct packed {
      logic     take_req;
      logic     rd_sbox;
      logic     run_round;
      logic     wait_rsp;
      cond_type jmp_cond;
      step_type jmp_step;
      step_type seq_step;
   } ucode_type;

   // Microcode store. Idle waits for an encrypt request, then each round is
   // one s-box read step followed by one round step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      word = '{take_req: 1'b0, rd_sbox: 1'b0, run_round: 1'b0, wait_rsp: 1'b0,
               jmp_cond: COND_ALWAYS, jmp_step: STEP_IDLE, seq_step: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            word.take_req = 1'b1;
            word.jmp_cond = COND_START;
            word.jmp_step = STEP_READ;
            word.seq_step = STEP_IDLE;
         end
         STEP_READ: begin
            word.rd_sbox  = 1'b1;
            word.jmp_cond = COND_ALWAYS;
            word.jmp_step = STEP_ROUND;
         end
         STEP_ROUND: begin
            word.run_round = 1'b1;
            word.wait_rsp  = 1'b1;
            word.jmp_cond  = COND_MORE;
            word.jmp_step  = STEP_READ;
            word.seq_step  = STEP_IDLE;
         end
         default: begin
            word.jmp_cond = COND_ALWAYS;
            word.jmp_step = STEP_IDLE;
         end
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

>>> rtl/blowfish_block_encrypt.sv
// Blowfish block engine top level: table loads, microcoded round sequencer,
// s-box memories and result register. Depends on bf_pkg.
//
// Usage: one request channel (req_valid/req_ready, payload req_type) and one
// result channel (rsp_valid/rsp_ready, payload rsp_type). A request with func
// FUNC_SUBKEY writes one subkey word (indexes 18 and up are dropped), FUNC_SBOX
// writes one s-box word (box = table_index[9:8]), and FUNC_ENCRYPT runs
// ROUND_COUNT Feistel rounds on left_half/right_half. Loads and the unused
// code give no result and leave the sequencer idle. Software loads every
// table entry an encryption reads before it sends the encrypt request.
// An encryption keeps the sequencer busy until its last round step, and
// the result is registered as the sequencer returns to idle. Each round is
// a read step for the registered read of the four s-box memories, then a
// round step for F and the half swap. Requests are taken only while the
// sequencer is idle. Reset clears the sequencer and the result valid flag;
// the tables keep their contents and are undefined after power-up. If the
// receiver stalls, the finished result waits in the output register and a
// new block may be taken; that block holds in its last round until the
// register frees up.
`default_nettype none

module blowfish_block_encrypt
   import bf_pkg::*;
#(
   parameter int unsigned ROUND_COUNT = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int unsigned RND_W = $clog2(ROUND_COUNT);

   // Sequencer.
   step_type   step_ff, step_in;
   ucode_type  ctl;
   logic       cond_hit;
   logic       stall;

   // Datapath.
   logic [31:0]      l_ff, l_in;
   logic [31:0]      r_ff, r_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic [31:0]      sk_ff [SUBKEY_DEPTH];
   logic [31:0]      sbox_mem [SBOX_COUNT][SBOX_DEPTH];
   logic [31:0]      sbox_q [SBOX_COUNT];
   logic [31:0]      f_val;
   logic [31:0]      k_nxt;
   logic [SK_IDX_W-1:0] k_idx;
   logic             last_round;

   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    rsp_busy;

   logic req_fire;
   logic start;

   assign ctl       = ucode_rom(step_ff);
   assign req_ready = ctl.take_req;
   assign req_fire  = req_valid && req_ready;
   assign start     = req_fire && (req_payload.func == FUNC_ENCRYPT);

   assign last_round = (rnd_ff == RND_W'(ROUND_COUNT - 1));
   assign rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign stall      = ctl.wait_rsp && last_round && rsp_busy;

   always_comb begin
      case (ctl.jmp_cond)
         COND_ALWAYS: cond_hit = 1'b1;
         COND_START:  cond_hit = start;
         COND_MORE:   cond_hit = !last_round;
         default:     cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      if (stall) begin
         step_in = step_ff;
      end else if (cond_hit) begin
         step_in = ctl.jmp_step;
      end else begin
         step_in = ctl.seq_step;
      end
   end

   assign f_val = ((sbox_q[0] + sbox_q[1]) ^ sbox_q[2]) + sbox_q[3];
   assign k_idx = SK_IDX_W'(rnd_ff) + SK_IDX_W'(1);
   assign k_nxt = sk_ff[k_idx];

   always_comb begin
      l_in         = l_ff;
      r_in         = r_ff;
      rnd_in       = rnd_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (start) begin
         l_in   = req_payload.left_half ^ sk_ff[0];
         r_in   = req_payload.right_half;
         rnd_in = '0;
      end else if (ctl.run_round) begin
         if (!last_round) begin
            // Next subkey is folded in here so the read step can use l_ff.
            l_in   = r_ff ^ f_val ^ k_nxt;
            r_in   = l_ff;
            rnd_in = rnd_ff + RND_W'(1);
         end else if (!stall) begin
            // The last round skips the swap and applies the output whitening.
            rsp_data_in.cipher_left  = l_ff ^ sk_ff[SK_IDX_W'(ROUND_COUNT + 1)];
            rsp_data_in.cipher_right = r_ff ^ f_val ^ k_nxt;
            rsp_valid_in             = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff        <= l_in;
      r_ff        <= r_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_payload.func == FUNC_SUBKEY) &&
          (req_payload.table_index < 10'(SUBKEY_DEPTH))) begin
         sk_ff[req_payload.table_index[SK_IDX_W-1:0]] <= req_payload.table_word;
      end
   end

   // One memory per s-box; box n is addressed by byte n of the left half,
   // counting from the most significant byte.
   for (genvar n = 0; n < SBOX_COUNT; n++) begin : g_sbox
      always_ff @(posedge clock) begin
         if (req_fire && (req_payload.func == FUNC_SBOX) &&
             (req_payload.table_index[9:8] == 2'(n))) begin
            sbox_mem[n][req_payload.table_index[7:0]] <= req_payload.table_word;
         end
         if (ctl.rd_sbox) begin
            sbox_q[n] <= sbox_mem[n][l_ff[31-8*n -: 8]];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTH
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_IDLE) |-> !(req_valid && req_ready))
      else $error("request accepted while an encryption is running");

   a_result_from_round: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(step_ff) == STEP_ROUND))
      else $error("result raised outside a round step");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (rnd_ff <= RND_W'(ROUND_COUNT - 1)))
      else $error("round counter beyond the last round");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      ((step_ff == STEP_ROUND) && last_round && rsp_valid_ff && !rsp_ready)
         |=> ((step_ff == STEP_ROUND) && rsp_valid_ff))
      else $error("last round left while the result register was full");
`endif

endmodule

`default_nettype wire
